// ===== sv/particle_attractor_accel_core_defines.svh =====
`ifndef PARTICLE_ATTRACTOR_ACCEL_CORE_DEFINES_SVH
`define PARTICLE_ATTRACTOR_ACCEL_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pac_pkg.sv =====
package pac_pkg;

    localparam int MAX_ATTRACTORS_DEF = 8;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_ZERO_MASS = 2'd2;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_APPLY = 1'b1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       add_att;
        logic       rd_att;
        logic       diff;
        logic       shift;
        logic       sq;
        logic       sq_acc;
        logic       sqrt_start;
        logic       div_u;
        logic       div_a;
        logic       mul;
        logic       acc_add;
        logic       clr_j;
        logic       inc_j;
        logic       set_out;
        logic [1:0] axis;
    } pac_cmd_t;

    typedef struct packed {
        logic func;
        logic mass_zero;
        logic j_valid;
        logic big_zero;
        logic big_wide;
        logic sqrt_busy;
        logic len_zero;
        logic div_busy;
        logic out_free;
    } pac_sts_t;

endpackage

// ===== sv/pac_ctrl.sv =====
module pac_ctrl
    import pac_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pac_sts_t sts,
    output pac_cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_ADD      = 4'd2;
    localparam logic [3:0] S_CHECK    = 4'd3;
    localparam logic [3:0] S_RDWAIT   = 4'd4;
    localparam logic [3:0] S_NORM     = 4'd5;
    localparam logic [3:0] S_SQ       = 4'd6;
    localparam logic [3:0] S_SQLAST   = 4'd7;
    localparam logic [3:0] S_SQRT     = 4'd8;
    localparam logic [3:0] S_DIVU     = 4'd9;
    localparam logic [3:0] S_MUL      = 4'd10;
    localparam logic [3:0] S_DIVA     = 4'd11;
    localparam logic [3:0] S_OUT      = 4'd12;
    localparam logic [3:0] S_DIFF     = 4'd13;
    localparam logic [3:0] S_DIVSTART = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            axis_reg  <= AXIS_X;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.func == FUNC_ADD) begin
                    state_next = S_ADD;
                end else if (sts.mass_zero) begin
                    state_next = S_OUT;
                end else begin
                    cmd.clr_j  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_ADD: begin
                cmd.add_att = 1'b1;
                state_next  = S_OUT;
            end
            S_CHECK: begin
                if (sts.j_valid) begin
                    cmd.rd_att = 1'b1;
                    state_next = S_RDWAIT;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_RDWAIT: begin
                state_next = S_DIFF;
            end
            S_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = S_NORM;
            end
            S_NORM: begin
                if (sts.big_zero) begin
                    cmd.inc_j  = 1'b1;
                    state_next = S_CHECK;
                end else if (sts.big_wide) begin
                    cmd.shift = 1'b1;
                end else begin
                    axis_next  = AXIS_X;
                    state_next = S_SQ;
                end
            end
            S_SQ: begin
                cmd.sq     = 1'b1;
                cmd.sq_acc = (axis_reg != AXIS_X);
                if (axis_reg == AXIS_Z) begin
                    state_next = S_SQLAST;
                end else begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            S_SQLAST: begin
                cmd.sq_acc     = 1'b1;
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT;
            end
            S_SQRT: begin
                if (!sts.sqrt_busy) begin
                    if (sts.len_zero) begin
                        cmd.inc_j  = 1'b1;
                        state_next = S_CHECK;
                    end else begin
                        axis_next  = AXIS_X;
                        cmd.axis   = AXIS_X;
                        cmd.div_u  = 1'b1;
                        state_next = S_DIVU;
                    end
                end
            end
            S_DIVSTART: begin
                // unit divide for the axis just stepped to
                cmd.div_u  = 1'b1;
                state_next = S_DIVU;
            end
            S_DIVU: begin
                if (!sts.div_busy) begin
                    cmd.mul    = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.div_a  = 1'b1;
                state_next = S_DIVA;
            end
            S_DIVA: begin
                if (!sts.div_busy) begin
                    cmd.acc_add = 1'b1;
                    if (axis_reg == AXIS_Z) begin
                        cmd.inc_j  = 1'b1;
                        state_next = S_CHECK;
                    end else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_DIVSTART;
                    end
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.set_out = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/pac_dp.sv =====
module pac_dp
    import pac_pkg::*;
#(
    parameter int MAX_ATTRACTORS = MAX_ATTRACTORS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pac_cmd_t           cmd,
    output pac_sts_t           sts,
    input  logic [31:0]        strength,
    input  logic               s_func,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic [30:0]        s_mass,
    input  logic signed [47:0] s_acc_x_in,
    input  logic signed [47:0] s_acc_y_in,
    input  logic signed [47:0] s_acc_z_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_acc_x_out,
    output logic signed [47:0] m_acc_y_out,
    output logic signed [47:0] m_acc_z_out,
    output logic [3:0]         m_attractors_loaded,
    output logic [1:0]         m_status
);

    localparam int CW = $clog2(MAX_ATTRACTORS + 1);
    localparam int IW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ATTRACTORS);
    localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

    logic [95:0] mem [MAX_ATTRACTORS];
    logic [95:0] rd_reg;

    logic               func_reg;
    logic [31:0]        pos_reg [3];
    logic [30:0]        mass_reg;
    logic signed [47:0] acc_reg [3];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      j_reg;
    logic               full_reg;

    logic [32:0] mag_reg [3];
    logic        neg_reg [3];
    logic [59:0] prod_reg;
    logic [63:0] len2_reg;

    logic [63:0] sq_v_reg, sq_res_reg;
    logic [5:0]  sq_k_reg;
    logic        sq_busy_reg;

    logic [30:0] den_reg;
    logic [30:0] rem_reg;
    logic [47:0] dsh_reg;
    logic [47:0] quo_reg;
    logic [5:0]  dcnt_reg;
    logic        div_busy_reg;
    logic [31:0] f_reg;

    logic               mv_reg;
    logic signed [47:0] ox_reg, oy_reg, oz_reg;
    logic [1:0]         ost_reg;
    logic [3:0]         oload_reg;

    logic [32:0] att_c [3];
    logic [32:0] d_c   [3];
    logic [63:0] sq_bit;
    logic [63:0] sq_try;
    logic [31:0] d_trial;
    logic [64:0] mul_p;
    logic [49:0] add_a, add_s;
    logic [CW+3:0] cnt_ext;

    assign att_c[0] = {rd_reg[31], rd_reg[31:0]};
    assign att_c[1] = {rd_reg[63], rd_reg[63:32]};
    assign att_c[2] = {rd_reg[95], rd_reg[95:64]};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_c[i] = att_c[i] - {pos_reg[i][31], pos_reg[i]};
        end
    end

    assign sq_bit  = 64'd1 << {sq_k_reg[4:0], 1'b0};
    assign sq_try  = sq_res_reg + sq_bit;
    assign d_trial = {rem_reg, dsh_reg[47]};
    assign mul_p   = strength * quo_reg[32:0];
    assign add_a   = neg_reg[cmd.axis] ? -{2'b00, quo_reg} : {2'b00, quo_reg};
    assign add_s   = {{2{acc_reg[cmd.axis][47]}}, acc_reg[cmd.axis]} + add_a;
    assign cnt_ext = {4'd0, count_reg};

    // attractor table, one row of three coordinates per entry
    always_ff @(posedge aclk) begin
        if (cmd.add_att && count_reg != MAX_CNT) begin
            mem[count_reg[IW-1:0]] <= {pos_reg[2], pos_reg[1], pos_reg[0]};
        end
        if (cmd.rd_att) begin
            rd_reg <= mem[j_reg[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            j_reg        <= '0;
            sq_busy_reg  <= 1'b0;
            div_busy_reg <= 1'b0;
            mv_reg       <= 1'b0;
        end else begin
            if (cmd.add_att && count_reg != MAX_CNT) count_reg <= count_reg + 1'b1;
            if (cmd.clr_j) j_reg <= '0;
            else if (cmd.inc_j) j_reg <= j_reg + 1'b1;
            if (cmd.sqrt_start) sq_busy_reg <= 1'b1;
            else if (sq_busy_reg && sq_k_reg == 6'd0) sq_busy_reg <= 1'b0;
            if (cmd.div_u || cmd.div_a) div_busy_reg <= 1'b1;
            else if (div_busy_reg && dcnt_reg == 6'd1) div_busy_reg <= 1'b0;
            if (cmd.set_out) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg   <= s_func;
            pos_reg[0] <= s_pos_x;
            pos_reg[1] <= s_pos_y;
            pos_reg[2] <= s_pos_z;
            mass_reg   <= s_mass;
            acc_reg[0] <= s_acc_x_in;
            acc_reg[1] <= s_acc_y_in;
            acc_reg[2] <= s_acc_z_in;
        end
        if (cmd.add_att) full_reg <= (count_reg == MAX_CNT);
        else if (cmd.load_in) full_reg <= 1'b0;
        if (cmd.acc_add) begin
            if (add_s[49:47] != {3{add_s[49]}}) begin
                acc_reg[cmd.axis] <= add_s[49] ? ACC_MIN : ACC_MAX;
            end else begin
                acc_reg[cmd.axis] <= add_s[47:0];
            end
        end
        if (cmd.diff) begin
            for (int i = 0; i < 3; i++) begin
                neg_reg[i] <= d_c[i][32];
                mag_reg[i] <= d_c[i][32] ? -d_c[i] : d_c[i];
            end
            len2_reg <= '0;
        end else if (cmd.shift) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= mag_reg[i] >> 1;
            end
        end
        if (cmd.sq) prod_reg <= mag_reg[cmd.axis][29:0] * mag_reg[cmd.axis][29:0];
        if (cmd.sq_acc) len2_reg <= len2_reg + {4'd0, prod_reg};
        // bit-pair square root, one result bit per cycle
        if (cmd.sqrt_start) begin
            sq_v_reg   <= len2_reg + {4'd0, prod_reg};
            sq_res_reg <= '0;
            sq_k_reg   <= 6'd31;
        end else if (sq_busy_reg) begin
            if (sq_v_reg >= sq_try) begin
                sq_v_reg   <= sq_v_reg - sq_try;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit;
            end else begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_k_reg <= sq_k_reg - 6'd1;
        end
        // restoring divider, one quotient bit per cycle
        if (cmd.div_u) begin
            den_reg  <= sq_res_reg[30:0];
            rem_reg  <= {2'd0, mag_reg[cmd.axis][29:1]};
            dsh_reg  <= {mag_reg[cmd.axis][0], 47'd0};
            quo_reg  <= '0;
            dcnt_reg <= 6'd33;
        end else if (cmd.div_a) begin
            den_reg  <= mass_reg;
            rem_reg  <= '0;
            dsh_reg  <= {f_reg, 16'd0};
            quo_reg  <= '0;
            dcnt_reg <= 6'd48;
        end else if (div_busy_reg) begin
            if (d_trial >= {1'b0, den_reg}) begin
                rem_reg <= 31'(d_trial - {1'b0, den_reg});
                quo_reg <= {quo_reg[46:0], 1'b1};
            end else begin
                rem_reg <= d_trial[30:0];
                quo_reg <= {quo_reg[46:0], 1'b0};
            end
            dsh_reg  <= dsh_reg << 1;
            dcnt_reg <= dcnt_reg - 6'd1;
        end
        if (cmd.mul) f_reg <= mul_p[63:32];
        if (cmd.set_out) begin
            oload_reg <= cnt_ext[3:0];
            if (func_reg == FUNC_ADD) begin
                ox_reg  <= '0;
                oy_reg  <= '0;
                oz_reg  <= '0;
                ost_reg <= full_reg ? STATUS_FULL : STATUS_OK;
            end else begin
                ox_reg  <= acc_reg[0];
                oy_reg  <= acc_reg[1];
                oz_reg  <= acc_reg[2];
                ost_reg <= (mass_reg == '0) ? STATUS_ZERO_MASS : STATUS_OK;
            end
        end
    end

    always_comb begin
        sts.func      = func_reg;
        sts.mass_zero = (mass_reg == '0);
        sts.j_valid   = (j_reg < count_reg);
        sts.big_zero  = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);
        sts.big_wide  = (mag_reg[0][32:30] != '0) || (mag_reg[1][32:30] != '0)
                     || (mag_reg[2][32:30] != '0);
        sts.sqrt_busy = sq_busy_reg;
        sts.len_zero  = (sq_res_reg[30:0] == '0);
        sts.div_busy  = div_busy_reg;
        sts.out_free  = !mv_reg || m_ready;
    end

    assign m_valid             = mv_reg;
    assign m_acc_x_out         = ox_reg;
    assign m_acc_y_out         = oy_reg;
    assign m_acc_z_out         = oz_reg;
    assign m_status            = ost_reg;
    assign m_attractors_loaded = oload_reg;

endmodule

// ===== sv/particle_attractor_accel_core.sv =====
// attractor force accumulator
// input channel (s_*): one beat per item; s_func = 0 appends an attractor at
//   s_pos_*, s_func = 1 applies every stored attractor to a particle
// result channel (m_*): exactly one beat per input beat, in order
// config: apb-style port, strength register (unsigned q0.32) at address 0,
//   write only while the block is idle
// flow: an add or a zero-mass particle goes straight to the result register;
//   a particle runs, per stored attractor, a square root of 32 steps, then
//   per axis a 33-step and a 48-step divide on the one shared divider, after
//   halving a far attractor (two halvings at most); a coincident one is skipped
// one item is in flight at a time; s_ready is high only when the
//   controller is idle, while a finished result may still wait in the
//   output register
// receiver stall: the result holds on m_* until m_ready; the next item can
//   be taken and worked on meanwhile, and waits at its end for the register
// reset: attractor count and strength clear, m_valid drops; table
//   contents stay undefined until written
module particle_attractor_accel_core
    import pac_pkg::*;
#(
    parameter int MAX_ATTRACTORS = MAX_ATTRACTORS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic [30:0]        s_mass,
    input  logic signed [47:0] s_acc_x_in,
    input  logic signed [47:0] s_acc_y_in,
    input  logic signed [47:0] s_acc_z_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_acc_x_out,
    output logic signed [47:0] m_acc_y_out,
    output logic signed [47:0] m_acc_z_out,
    output logic [3:0]         m_attractors_loaded,
    output logic [1:0]         m_status
);

    logic [31:0] strength_reg;
    pac_cmd_t    cmd;
    pac_sts_t    sts;
    logic        s_ready_int;

    // strength register, index from paddr[2]
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strength_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            strength_reg <= pwdata;
        end
    end

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == 1'b0) ? strength_reg : '0;
    assign s_ready = s_ready_int;

    pac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready_int),
        .sts     (sts),
        .cmd     (cmd)
    );

    pac_dp #(
        .MAX_ATTRACTORS (MAX_ATTRACTORS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .strength            (strength_reg),
        .s_func              (s_func),
        .s_pos_x             (s_pos_x),
        .s_pos_y             (s_pos_y),
        .s_pos_z             (s_pos_z),
        .s_mass              (s_mass),
        .s_acc_x_in          (s_acc_x_in),
        .s_acc_y_in          (s_acc_y_in),
        .s_acc_z_in          (s_acc_z_in),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_acc_x_out         (m_acc_x_out),
        .m_acc_y_out         (m_acc_y_out),
        .m_acc_z_out         (m_acc_z_out),
        .m_attractors_loaded (m_attractors_loaded),
        .m_status            (m_status)
    );

endmodule

// ===== sv/pac_checker.sv =====
`include "particle_attractor_accel_core_defines.svh"

module pac_checker
    import pac_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [47:0] m_acc_x_out,
    input logic [47:0] m_acc_y_out,
    input logic [47:0] m_acc_z_out,
    input logic [1:0]  m_status
);

    `PAC_ASSERT_NEXT(a_hold_valid, m_valid && !m_ready, m_valid, "result beat dropped")
    `PAC_ASSERT_NOW(a_status_code, m_valid, m_status != 2'd3, "bad status code")
    `PAC_ASSERT_NOW(a_full_zero, m_valid && m_status == STATUS_FULL,
        m_acc_x_out == '0 && m_acc_y_out == '0 && m_acc_z_out == '0, "full add not zero")
    `PAC_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "second item taken")

endmodule

bind particle_attractor_accel_core pac_checker u_pac_checker (.*);
